@@ src/spq_pkg.sv @@
// spq_pkg: shared constants and types for the sorted priority queue
// holds capacity, widths, status and op codes and the cell command struct
// no dependencies
package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int KEY_W    = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int OCC_W    = 5;
   localparam int STATUS_W = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // command broadcast to every cell
   typedef struct packed {
      logic                    insert;
      logic                    remove;
      logic signed [KEY_W-1:0] key;
   } cell_cmd_type;

endpackage

@@ src/spq_cell.sv @@
// spq_cell: one slot of the sorted chain, holds one key
// compares against the broadcast key and shifts with its neighbors
// depends on spq_pkg
module spq_cell (
   input  logic                            clock,
   input  spq_pkg::cell_cmd_type           cmd,
   input  logic                            occupied,
   input  logic                            left_keep,
   input  logic signed [spq_pkg::KEY_W-1:0] left_key,
   input  logic signed [spq_pkg::KEY_W-1:0] right_key,
   output logic                            keep,
   output logic signed [spq_pkg::KEY_W-1:0] key_out
);

   logic signed [spq_pkg::KEY_W-1:0] key_ff;
   logic signed [spq_pkg::KEY_W-1:0] key_in;

   // stored key stays ahead of an equal new key
   assign keep    = occupied && (key_ff <= cmd.key);
   assign key_out = key_ff;

   always_comb begin
      key_in = key_ff;
      if (cmd.insert) begin
         if (!keep) begin
            key_in = left_keep ? cmd.key : left_key;
         end
      end else if (cmd.remove) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

@@ src/sorted_priority_queue_top.sv @@
// sorted_priority_queue_top: minimum priority queue built as a chain of key cells
// instantiates spq_cell once per slot, keeps the count and the result register
// depends on spq_pkg and spq_cell
//
// The queue holds up to spq_pkg::CAPACITY signed 32-bit keys in ascending
// order, one key per cell. On an insert each cell compares its key with the
// broadcast key in parallel and either keeps its key, takes the new key or
// takes its left neighbor's key; on a remove every cell takes its right
// neighbor's key and the front cell's key is returned. Equal keys leave in
// arrival order. Each item gives exactly one result: status ok, full
// (insert dropped, queue unchanged) or empty (remove on an empty queue,
// removed key reads zero), plus the occupancy after the item. Results sit
// in an output register, so a new item is taken in the same cycle the
// previous result is taken, giving one item per cycle while the result
// side does not stall. Cell contents are not cleared at reset; only the key
// count and result valid flag are; slots past the count are never read.
module sorted_priority_queue_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic signed [spq_pkg::KEY_W-1:0]    req_key,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [spq_pkg::KEY_W-1:0]    rsp_removed_key,
   output logic                                rsp_key_valid,
   output logic [spq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [spq_pkg::OCC_W-1:0]           rsp_occupancy
);

   localparam int N = spq_pkg::CAPACITY;

   // control state
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [spq_pkg::CNT_W-1:0] count_ff, count_in;

   // result payload
   logic signed [spq_pkg::KEY_W-1:0] removed_ff, removed_in;
   logic                             kvalid_ff, kvalid_in;
   logic [spq_pkg::STATUS_W-1:0]     status_ff, status_in;

   logic                  accept;
   logic                  is_full, is_empty;
   spq_pkg::cell_cmd_type cmd;

   // chain wiring
   logic [N-1:0]                     occupied;
   logic [N-1:0]                     keep;
   logic signed [spq_pkg::KEY_W-1:0] cell_key [N];

   // occupancy reported modulo 2**OCC_W
   logic [spq_pkg::CNT_W+spq_pkg::OCC_W-1:0] count_ext;

   // take a new item whenever the result register is free or being emptied
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign is_full  = (count_ff == spq_pkg::CNT_W'(N));
   assign is_empty = (count_ff == '0);

   // only effective operations move the chain
   assign cmd.insert = accept && (req_op == spq_pkg::OP_INSERT) && !is_full;
   assign cmd.remove = accept && (req_op == spq_pkg::OP_REMOVE) && !is_empty;
   assign cmd.key    = req_key;

   for (genvar i = 0; i < N; i++) begin : g_cell
      logic                             lk;
      logic signed [spq_pkg::KEY_W-1:0] lkey;
      logic signed [spq_pkg::KEY_W-1:0] rkey;

      assign occupied[i] = (count_ff > spq_pkg::CNT_W'(i));

      if (i == 0) begin : g_first
         // nothing stored ahead of the front cell
         assign lk   = 1'b0;
         assign lkey = req_key;
      end else begin : g_inner
         assign lk   = keep[i-1];
         assign lkey = cell_key[i-1];
      end

      if (i == N - 1) begin : g_last
         // last slot empties on a remove, its value is never read
         assign rkey = cell_key[i];
      end else begin : g_body
         assign rkey = cell_key[i+1];
      end

      spq_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .occupied  (occupied[i]),
         .left_keep (lk),
         .left_key  (lkey),
         .right_key (rkey),
         .keep      (keep[i]),
         .key_out   (cell_key[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      removed_in   = removed_ff;
      kvalid_in    = kvalid_ff;
      status_in    = status_ff;

      if (!req_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
         removed_in   = '0;
         kvalid_in    = 1'b0;
         status_in    = spq_pkg::STATUS_OK;
         case (req_op)
            spq_pkg::OP_INSERT: begin
               if (is_full) begin
                  status_in = spq_pkg::STATUS_FULL;
               end else begin
                  count_in = count_ff + spq_pkg::CNT_W'(1);
               end
            end
            spq_pkg::OP_REMOVE: begin
               if (is_empty) begin
                  status_in = spq_pkg::STATUS_EMPTY;
               end else begin
                  removed_in = cell_key[0];
                  kvalid_in  = 1'b1;
                  count_in   = count_ff - spq_pkg::CNT_W'(1);
               end
            end
            default: begin
               status_in = spq_pkg::STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      removed_ff <= removed_in;
      kvalid_ff  <= kvalid_in;
      status_ff  <= status_in;
   end

   assign count_ext = {{spq_pkg::OCC_W{1'b0}}, count_ff};

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_removed_key = removed_ff;
   assign rsp_key_valid   = kvalid_ff;
   assign rsp_status      = status_ff;
   // count register already holds the value after the item in the register
   assign rsp_occupancy   = count_ext[spq_pkg::OCC_W-1:0];

endmodule

@@ dv/spq_scoreboard_pkg.sv @@
`timescale 1ns / 100ps
// spq_scoreboard_pkg: scoreboard for the sorted priority queue testbench
// keeps its own sorted copy of the queue and checks each result item in order
// depends on spq_pkg
package spq_scoreboard_pkg;

   typedef struct packed {
      logic signed [spq_pkg::KEY_W-1:0] removed_key;
      logic                             key_valid;
      logic [spq_pkg::STATUS_W-1:0]     status;
      logic [spq_pkg::OCC_W-1:0]        occupancy;
   } spq_result_type;

   class spq_scoreboard;
      logic signed [spq_pkg::KEY_W-1:0] held_keys[$];  // ascending, oldest of equals first
      spq_result_type                   expected_results[$];
      int                               failures = 0;

      function void note_item(logic op, logic signed [spq_pkg::KEY_W-1:0] key);
         spq_result_type exp_res;
         int             pos;
         exp_res = '0;
         exp_res.status = spq_pkg::STATUS_OK;
         if (op == spq_pkg::OP_INSERT) begin
            if (held_keys.size() >= spq_pkg::CAPACITY) begin
               exp_res.status = spq_pkg::STATUS_FULL;
            end else begin
               pos = 0;
               while (pos < held_keys.size() && held_keys[pos] <= key) pos++;
               held_keys.insert(pos, key);
            end
         end else begin
            if (held_keys.size() == 0) begin
               exp_res.status = spq_pkg::STATUS_EMPTY;
            end else begin
               exp_res.removed_key = held_keys.pop_front();
               exp_res.key_valid   = 1'b1;
            end
         end
         exp_res.occupancy = spq_pkg::OCC_W'(held_keys.size());
         expected_results.push_back(exp_res);
      endfunction

      function void check_result(spq_result_type got);
         spq_result_type exp_res;
         if (expected_results.size() == 0) begin
            $error("result item with no item outstanding");
            failures++;
            return;
         end
         exp_res = expected_results.pop_front();
         if (got.removed_key !== exp_res.removed_key) begin
            $error("removed_key: expected %0d, got %0d", exp_res.removed_key, got.removed_key);
            failures++;
         end
         if (got.key_valid !== exp_res.key_valid) begin
            $error("key_valid: expected %0d, got %0d", exp_res.key_valid, got.key_valid);
            failures++;
         end
         if (got.status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, got.status);
            failures++;
         end
         if (got.occupancy !== exp_res.occupancy) begin
            $error("occupancy: expected %0d, got %0d", exp_res.occupancy, got.occupancy);
            failures++;
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

endpackage

@@ dv/tb_sorted_priority_queue_top.sv @@
`timescale 1ns / 100ps
// tb_sorted_priority_queue_top: testbench for the sorted minimum priority queue
// drives insert and remove items with random gaps and stalls, checks each result
// depends on spq_pkg, spq_scoreboard_pkg and sorted_priority_queue_top
module tb_sorted_priority_queue_top;

   // cycles with no item moving on either side before the run is called hung
   localparam int IDLE_LIMIT     = 2000;
   // length of the one long receiver hold-off, and how many results come first
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int HOLD_OFF_AFTER  = 300;
   localparam int RANDOM_ITEMS    = 1424;
   localparam int PHASE_ITEMS     = 100;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic                             req_op;
   logic signed [spq_pkg::KEY_W-1:0] req_key;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic signed [spq_pkg::KEY_W-1:0] rsp_removed_key;
   logic                             rsp_key_valid;
   logic [spq_pkg::STATUS_W-1:0]     rsp_status;
   logic [spq_pkg::OCC_W-1:0]        rsp_occupancy;

   spq_scoreboard_pkg::spq_scoreboard  sb;
   spq_scoreboard_pkg::spq_result_type got_result;
   int                                 results_seen = 0;
   int                                 idle_cycles  = 0;

   sorted_priority_queue_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_removed_key (rsp_removed_key),
      .rsp_key_valid   (rsp_key_valid),
      .rsp_status      (rsp_status),
      .rsp_occupancy   (rsp_occupancy)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // gap length for either side: mode 0 is a stretch with no idling,
   // otherwise mostly short gaps with an occasional long one
   function automatic int pick_gap(int mode);
      int r;
      if (mode == 0) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // key mix: full-range values, a narrow band so equal keys pile up,
   // and the signed extremes around zero and the sign boundary
   function automatic logic signed [spq_pkg::KEY_W-1:0] pick_key();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom;
         5, 6, 7:       return $signed($urandom_range(0, 15)) - 8;
         8: begin
            case ($urandom_range(0, 3))
               0:       return 32'sh7FFF_FFFF;
               1:       return 32'sh8000_0000;
               2:       return '0;
               default: return -1;
            endcase
         end
         default:       return 32'sh8000_0000 + $signed($urandom_range(0, 3))
                               - $signed($urandom_range(0, 3));
      endcase
   endfunction

   // offer one item after an optional gap, hold it until it is taken
   task automatic send_item(logic op, logic signed [spq_pkg::KEY_W-1:0] key, int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_op    <= op;
      req_key   <= key;
      do @(posedge clock); while (req_stall);
      sb.note_item(op, key);
   endtask

   // result side: every taken result is checked against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_result.removed_key = rsp_removed_key;
         got_result.key_valid   = rsp_key_valid;
         got_result.status      = rsp_status;
         got_result.occupancy   = rsp_occupancy;
         sb.check_result(got_result);
         results_seen++;
      end
   end

   // watchdog on cycles where nothing moves
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // receiver stalls; one long hold-off lets the sender back up into the block
   initial begin : receiver
      int rx_mode;
      int stretch;
      int stall_len;
      bit held_off;
      rx_mode   = 0;
      stretch   = 0;
      held_off  = 1'b0;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            held_off = 1'b1;
         end else begin
            stall_len = pick_gap(rx_mode);
            if (stall_len > 0) begin
               rsp_stall <= 1'b1;
               repeat (stall_len) @(negedge clock);
            end
            rsp_stall <= 1'b0;
            @(negedge clock);
            stretch += stall_len + 1;
            // switch between free-flowing and stalling stretches now and then
            if (stretch >= 200) begin
               stretch = 0;
               rx_mode = $urandom_range(0, 2);
            end
         end
      end
   end

   // sender: reset, directed items, then phases of random items
   initial begin : sender
      logic signed [spq_pkg::KEY_W-1:0] fill_keys [16];
      int insert_pct;
      int tx_mode;
      logic op;
      sb = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_op    = spq_pkg::OP_INSERT;
      req_key   = '0;
      fill_keys = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sh1, 32'sh1,
                    32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7, 32'sh7, 32'sh7,
                    -32'sh7, 32'sh64, -32'sh64, 32'sh4000_0000, 32'shC000_0000,
                    32'sh3};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // remove on an empty queue
      send_item(spq_pkg::OP_REMOVE, 32'sh5A5A_A5A5, 0);
      // fill to capacity with extremes and equal keys, back to back
      foreach (fill_keys[i]) send_item(spq_pkg::OP_INSERT, fill_keys[i], 0);
      // insert into a full queue is dropped
      send_item(spq_pkg::OP_INSERT, 32'sh2A, 0);
      // drain part of it, smallest first
      repeat (8) send_item(spq_pkg::OP_REMOVE, '1, $urandom_range(0, 1));

      // random phases with a drifting insert share so the occupancy
      // sweeps from empty to full and back
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_ITEMS == 0) begin
            case ($urandom_range(0, 4))
               0:       insert_pct = 10;
               1:       insert_pct = 30;
               2:       insert_pct = 50;
               3:       insert_pct = 70;
               default: insert_pct = 90;
            endcase
            tx_mode = $urandom_range(0, 2);
         end
         op = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
         send_item(op, pick_key(), pick_gap(tx_mode));
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then let anything stray arrive
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ sorted_priority_queue_top.f @@
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue_top.sv
dv/spq_scoreboard_pkg.sv
dv/tb_sorted_priority_queue_top.sv
